// ===== rtl/sti_pkg.sv =====
// Package for the segment table insert block: types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;
    localparam int NUM_GROUPS_DEF = 32;
    localparam int GROUP_WAYS_DEF = 8;
    localparam int ESID_W = 36;
    localparam int VSID_W = 52;
    localparam int IDX_W = 8;
    localparam int CNT_W = 8;
    localparam logic [ESID_W-1:0] THRESH_RESET = 36'hC00000000;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIM_RD,
        S_PRIM_CHK,
        S_SEC_RD,
        S_SEC_CHK,
        S_RING_RD,
        S_RING_CHK,
        S_WRITE,
        S_FL_RD,
        S_FL_CHK,
        S_RD_RD,
        S_RD_OUT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic prim_scan;  // scan primary group way by way
        logic sec_scan;
        logic ring_scan;
        logic fl_scan;
        logic rd_issue;
        logic step;       // advance scan counter
        logic wr_new;     // write the new entry at chosen slot
        logic fl_clear;   // clear valid bit of current flush slot
        logic emit;       // drive result strobe
        logic castout;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cur_valid;  // valid bit at current address
        logic cur_ok;     // castout rule holds for entry read
        logic cur_flush;  // entry should be flushed
        logic last;       // scan counter at last position
    } t_status;

    function automatic logic castout_ok(input logic [ESID_W-1:0] esid);
        return (esid[ESID_W-1:32] == '0) || (esid[31:0] != '0);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/segment_table_insert.sv =====
// Segment table insert block, top level: controller plus datapath.
// Insert: probes up to 16 group ways (primary group, then secondary group) and then
// up to 16 ring positions before the write and the result. Flush scans entries 1..255.
// Read returns the entry at the read index. One item at a time, busy until the result
// cycle; results cannot be held off. Reset (synchronous, active low) clears the
// valid bits, sets the pointer to 1 and the threshold to its reset value.
// Depends on sti_pkg, sti_ctrl, sti_dp, sti_ram.
`timescale 1ns / 1ps
`default_nettype none
module segment_table_insert
    import sti_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               i_cfg_we,
    input  wire [ESID_W-1:0]  i_cfg_wdata,
    input  wire [1:0]         i_action,
    input  wire [ESID_W-1:0]  i_seg_id,
    input  wire [VSID_W-1:0]  i_virt_seg_id,
    input  wire [IDX_W-1:0]   i_read_index,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_slot,
    output logic              o_was_castout,
    output logic              o_entry_valid,
    output logic [ESID_W-1:0] o_esid_out,
    output logic [VSID_W-1:0] o_vsid_out,
    output logic [CNT_W-1:0]  o_cleared_count
);
    t_cmd w_cmd;
    t_status w_status;

    sti_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_action(i_action),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy));

    sti_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_action(i_action), .i_seg_id(i_seg_id), .i_virt_seg_id(i_virt_seg_id),
        .i_read_index(i_read_index), .o_status(w_status), .o_done(o_valid),
        .o_slot(o_slot), .o_was_castout(o_was_castout),
        .o_entry_valid(o_entry_valid), .o_esid_out(o_esid_out),
        .o_vsid_out(o_vsid_out), .o_cleared_count(o_cleared_count));
endmodule
`default_nettype wire

// ===== rtl/sti_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/sti_ctrl.sv =====
// Controller state machine for the segment table insert block.
// Depends on sti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sti_ctrl
    import sti_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_start,
    input  wire [1:0] i_action,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_INSERT: n_state = S_PRIM_RD;
                        ACT_FLUSH: n_state = S_FL_RD;
                        ACT_READ: n_state = S_RD_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PRIM_RD: n_state = S_PRIM_CHK;
            S_PRIM_CHK: begin
                if (!i_status.cur_valid) n_state = S_WRITE;
                else if (i_status.last) n_state = S_SEC_RD;
                else n_state = S_PRIM_RD;
            end
            S_SEC_RD: n_state = S_SEC_CHK;
            S_SEC_CHK: begin
                if (!i_status.cur_valid) n_state = S_WRITE;
                else if (i_status.last) n_state = S_RING_RD;
                else n_state = S_SEC_RD;
            end
            S_RING_RD: n_state = S_RING_CHK;
            S_RING_CHK: begin
                if (i_status.cur_ok || i_status.last) n_state = S_WRITE;
                else n_state = S_RING_RD;
            end
            S_WRITE: n_state = S_IDLE;
            S_FL_RD: n_state = S_FL_CHK;
            S_FL_CHK: n_state = i_status.last ? S_DONE : S_FL_RD;
            S_RD_RD: n_state = S_RD_OUT;
            S_RD_OUT: n_state = S_IDLE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_PRIM_RD: begin
                o_cmd.prim_scan = 1'b1;
            end
            S_PRIM_CHK: begin
                o_cmd.prim_scan = 1'b1;
                o_cmd.step = i_status.cur_valid;
            end
            S_SEC_RD: begin
                o_cmd.sec_scan = 1'b1;
            end
            S_SEC_CHK: begin
                o_cmd.sec_scan = 1'b1;
                o_cmd.step = i_status.cur_valid;
            end
            S_RING_RD: begin
                o_cmd.ring_scan = 1'b1;
            end
            S_RING_CHK: begin
                o_cmd.ring_scan = 1'b1;
                o_cmd.step = !(i_status.cur_ok || i_status.last);
                o_cmd.castout = 1'b1;
            end
            S_WRITE: begin
                o_cmd.wr_new = 1'b1;
                o_cmd.emit = 1'b1;
            end
            S_FL_RD: begin
                o_cmd.fl_scan = 1'b1;
            end
            S_FL_CHK: begin
                o_cmd.fl_scan = 1'b1;
                o_cmd.fl_clear = i_status.cur_flush;
                o_cmd.step = 1'b1;
            end
            S_RD_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_RD_OUT: o_cmd.emit = 1'b1;
            S_DONE: o_cmd.emit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_write_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_PRIM_CHK ||
        $past(r_state) == S_SEC_CHK || $past(r_state) == S_RING_CHK))
        else $error("write entered from a non-check state");
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !o_cmd.emit)
        else $error("two results in a row");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("item taken while busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/sti_dp.sv =====
// Datapath for the segment table insert block: entry memories, valid bits,
// scan counters, rotate pointer and result registers. Depends on sti_pkg, sti_ram.
`timescale 1ns / 1ps
`default_nettype none
module sti_dp
    import sti_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire                i_cfg_we,
    input  wire [ESID_W-1:0]   i_cfg_wdata,
    input  wire [1:0]          i_action,
    input  wire [ESID_W-1:0]   i_seg_id,
    input  wire [VSID_W-1:0]   i_virt_seg_id,
    input  wire [IDX_W-1:0]    i_read_index,
    output t_status            o_status,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_slot,
    output logic               o_was_castout,
    output logic               o_entry_valid,
    output logic [ESID_W-1:0]  o_esid_out,
    output logic [VSID_W-1:0]  o_vsid_out,
    output logic [CNT_W-1:0]   o_cleared_count
);
    localparam int NUM_GROUPS = NUM_GROUPS_DEF;
    localparam int GROUP_WAYS = GROUP_WAYS_DEF;
    localparam int TABLE = NUM_GROUPS * GROUP_WAYS;
    localparam int AW = $clog2(TABLE);
    localparam int GW = $clog2(NUM_GROUPS);
    localparam int WW = $clog2(GROUP_WAYS);
    localparam int RW = WW + 1;

    logic [1:0]        r_action;
    logic [ESID_W-1:0] r_esid, r_thresh;
    logic [VSID_W-1:0] r_vsid;
    logic [IDX_W-1:0]  r_ridx;
    logic [TABLE-1:0]  r_valid;
    logic [RW-1:0]     r_ptr, r_start, r_pos;
    logic [WW-1:0]     r_way;
    logic [AW-1:0]     r_fl_addr, r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_castout, r_done;
    logic [ESID_W-1:0] r_old;
    logic [IDX_W-1:0]  r_slot;
    logic              r_ev;
    logic [ESID_W-1:0] r_eo;
    logic [VSID_W-1:0] r_vo;
    logic [CNT_W-1:0]  r_co;

    logic [GW-1:0] w_prim, w_sec;
    logic [AW-1:0] w_addr, w_ring_addr, w_rd_addr;
    logic [RW-1:0] w_fallback;
    logic [ESID_W-1:0] w_esid_rd;
    logic [VSID_W-1:0] w_vsid_rd;
    logic w_we, w_rd_in_range;

    assign w_prim = r_esid[GW-1:0];
    assign w_sec = ~w_prim;
    assign w_ring_addr = r_pos[RW-1] ? {w_sec, r_pos[WW-1:0]} : {w_prim, r_pos[WW-1:0]};
    assign w_rd_in_range = ({1'b0, r_ridx} < (IDX_W+1)'(TABLE));
    assign w_rd_addr = AW'(r_ridx);
    assign w_fallback = r_start - RW'(1);

    always_comb begin
        w_addr = r_addr;
        if (i_cmd.prim_scan) w_addr = {w_prim, r_way};
        else if (i_cmd.sec_scan) w_addr = {w_sec, r_way};
        else if (i_cmd.ring_scan) w_addr = w_ring_addr;
        else if (i_cmd.fl_scan) w_addr = r_fl_addr;
        else if (i_cmd.rd_issue) w_addr = w_rd_addr;
    end

    assign w_we = i_cmd.wr_new;

    sti_ram #(.WIDTH(ESID_W), .DEPTH(TABLE)) u_esid (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_esid), .o_rdata(w_esid_rd));
    sti_ram #(.WIDTH(VSID_W), .DEPTH(TABLE)) u_vsid (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_vsid), .o_rdata(w_vsid_rd));

    always_comb begin
        o_status.cur_valid = r_valid[w_addr];
        o_status.cur_ok = castout_ok(w_esid_rd);
        o_status.cur_flush = r_valid[w_addr] && (w_esid_rd < r_thresh)
            && (w_addr != '0);
        o_status.last = 1'b0;
        if (i_cmd.prim_scan || i_cmd.sec_scan) o_status.last = (r_way == WW'(GROUP_WAYS - 1));
        else if (i_cmd.ring_scan) o_status.last = (r_pos + RW'(1) == r_start);
        else if (i_cmd.fl_scan) o_status.last = (r_fl_addr == AW'(TABLE - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_valid <= '0;
            r_ptr <= RW'(1);
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) r_thresh <= i_cfg_wdata;
            r_done <= i_cmd.emit;
            if (i_cmd.fl_clear) r_valid[w_addr] <= 1'b0;
            if (i_cmd.wr_new) begin
                r_valid[w_addr] <= 1'b1;
                if (r_castout) r_ptr <= r_pos + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_esid <= i_seg_id;
            r_vsid <= i_virt_seg_id;
            r_ridx <= i_read_index;
            r_way <= '0;
            r_pos <= r_ptr;
            r_start <= r_ptr;
            r_fl_addr <= AW'(1);
            r_cnt <= '0;
            r_castout <= 1'b0;
        end else if (i_cmd.step) begin
            r_way <= r_way + WW'(1);
            r_pos <= r_pos + RW'(1);
            r_fl_addr <= r_fl_addr + AW'(1);
        end
        if ((i_cmd.prim_scan || i_cmd.sec_scan) && i_cmd.step && o_status.last)
            r_way <= '0;
        r_addr <= w_addr;
        if (i_cmd.castout) begin
            r_castout <= 1'b1;
            r_old <= w_esid_rd;
            if (!o_status.cur_ok && o_status.last) begin
                r_pos <= r_start;
                r_addr <= w_fallback[RW-1] ? {w_sec, w_fallback[WW-1:0]}
                    : {w_prim, w_fallback[WW-1:0]};
            end
        end
        if (i_cmd.fl_clear && r_cnt != CNT_MAX) r_cnt <= r_cnt + CNT_W'(1);
        if (i_cmd.wr_new) begin
            r_slot <= IDX_W'(w_addr);
            r_ev <= 1'b1;
            r_eo <= r_castout ? r_old : '0;
            r_vo <= r_vsid;
            r_co <= '0;
        end else if (i_cmd.emit) begin
            r_co <= '0;
            r_slot <= '0;
            r_ev <= 1'b0;
            r_eo <= '0;
            r_vo <= '0;
            if (r_action == ACT_FLUSH) r_co <= r_cnt;
            if (r_action == ACT_READ) begin
                r_slot <= r_ridx;
                if (w_rd_in_range) begin
                    r_ev <= r_valid[w_rd_addr];
                    r_eo <= w_esid_rd;
                    r_vo <= w_vsid_rd;
                end
            end
        end
    end

    // castout flag of the result follows the insert path only
    logic r_co_flag;
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_co_flag <= i_cmd.wr_new && r_castout;
    end

    assign o_done = r_done;
    assign o_slot = r_slot;
    assign o_was_castout = r_co_flag;
    assign o_entry_valid = r_ev;
    assign o_esid_out = r_eo;
    assign o_vsid_out = r_vo;
    assign o_cleared_count = r_co;

`ifndef ASSERT_OFF
    a_slot0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fl_clear |-> (w_addr != '0))
        else $error("flush cleared slot 0");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |=> r_valid[$past(w_addr)])
        else $error("written entry not valid");
    a_cnt_zero_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && o_was_castout) |-> (o_cleared_count == '0))
        else $error("count on insert");
`endif
endmodule
`default_nettype wire

// ===== tb/segment_table_insert_tb.sv =====
// Testbench for segment_table_insert: directed and random insert, flush, read and unused-action items
// checked against a scoreboard that keeps its own copy of the segment table.
// Depends on sti_pkg and the segment_table_insert RTL.
`timescale 1ns / 1ps

import sti_pkg::*;

typedef struct {
    logic [IDX_W-1:0]  slot;
    logic              castout;
    logic              valid;
    logic [ESID_W-1:0] esid;
    logic [VSID_W-1:0] vsid;
    logic [CNT_W-1:0]  count;
} seg_result_t;

class seg_table_sb;
    localparam int TBL = NUM_GROUPS_DEF * GROUP_WAYS_DEF;
    localparam int RING = 2 * GROUP_WAYS_DEF;

    bit                vld[TBL];
    bit                written[TBL];
    logic [ESID_W-1:0] esid_tab[TBL];
    logic [VSID_W-1:0] vsid_tab[TBL];
    int                rr_ptr;
    logic [ESID_W-1:0] thresh;
    seg_result_t       pending[$];
    int                errors;
    int                n_checked;
    int                n_castout;
    int                n_noqual;

    function void reset_state();
        foreach (vld[i]) begin
            vld[i] = 0;
            written[i] = 0;
        end
        rr_ptr = 1;
        thresh = THRESH_RESET;
        pending.delete();
    endfunction

    function bit castout_allowed(logic [ESID_W-1:0] e);
        return (e[ESID_W-1:32] == 0) || (e[31:0] != 0);
    endfunction

    function int ring_to_slot(int pos, int prim, int sec);
        if (pos < GROUP_WAYS_DEF) begin
            return prim * GROUP_WAYS_DEF + pos;
        end
        return sec * GROUP_WAYS_DEF + pos - GROUP_WAYS_DEF;
    endfunction

    function void note_item(logic [1:0] act, logic [ESID_W-1:0] sid,
                            logic [VSID_W-1:0] vid, logic [IDX_W-1:0] idx);
        seg_result_t r;
        int prim, sec, s, pos, start_pos, chosen;
        bit done;
        r = '{default: '0};
        if (act == ACT_INSERT) begin
            prim = int'(sid % NUM_GROUPS_DEF);
            sec = NUM_GROUPS_DEF - 1 - prim;
            done = 0;
            for (int g = 0; g < 2 && !done; g++) begin
                for (int w = 0; w < GROUP_WAYS_DEF && !done; w++) begin
                    s = (g ? sec : prim) * GROUP_WAYS_DEF + w;
                    if (!vld[s]) begin
                        done = 1;
                        chosen = s;
                    end
                end
            end
            if (!done) begin
                start_pos = rr_ptr;
                pos = start_pos;
                for (int i = 0; i < RING && !done; i++) begin
                    if (castout_allowed(esid_tab[ring_to_slot(pos, prim, sec)])) begin
                        done = 1;
                    end else begin
                        pos = (pos + 1) % RING;
                    end
                end
                if (done) begin
                    rr_ptr = (pos + 1) % RING;
                end else begin
                    pos = (start_pos + RING - 1) % RING;
                    rr_ptr = (start_pos + 1) % RING;
                    n_noqual++;
                end
                chosen = ring_to_slot(pos, prim, sec);
                r.castout = 1;
                r.esid = esid_tab[chosen];
                n_castout++;
            end
            r.slot = IDX_W'(chosen);
            r.valid = 1;
            r.vsid = vid;
            vld[chosen] = 1;
            written[chosen] = 1;
            esid_tab[chosen] = sid;
            vsid_tab[chosen] = vid;
        end else if (act == ACT_FLUSH) begin
            for (int i = 1; i < TBL; i++) begin
                if (vld[i] && esid_tab[i] < thresh) begin
                    vld[i] = 0;
                    if (r.count != CNT_MAX) r.count++;
                end
            end
        end else if (act == ACT_READ) begin
            r.slot = idx;
            r.valid = vld[idx];
            r.esid = esid_tab[idx];
            r.vsid = vsid_tab[idx];
        end
        pending.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, e, a);
            errors++;
        end
    endfunction

    function void check_result(seg_result_t a);
        seg_result_t e;
        if (pending.size() == 0) begin
            $display("%0t unexpected result: slot %h", $realtime, a.slot);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        cmp_field("slot", e.slot, a.slot);
        cmp_field("was_castout", e.castout, a.castout);
        cmp_field("entry_valid", e.valid, a.valid);
        cmp_field("esid_out", e.esid, a.esid);
        cmp_field("vsid_out", e.vsid, a.vsid);
        cmp_field("cleared_count", e.count, a.count);
    endfunction
endclass

module segment_table_insert_tb;
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic              i_cfg_we = 0;
    logic [ESID_W-1:0] i_cfg_wdata = '0;
    logic [1:0]        i_action = '0;
    logic [ESID_W-1:0] i_seg_id = '0;
    logic [VSID_W-1:0] i_virt_seg_id = '0;
    logic [IDX_W-1:0]  i_read_index = '0;
    logic              o_valid;
    logic [IDX_W-1:0]  o_slot;
    logic              o_was_castout;
    logic              o_entry_valid;
    logic [ESID_W-1:0] o_esid_out;
    logic [VSID_W-1:0] o_vsid_out;
    logic [CNT_W-1:0]  o_cleared_count;

    seg_table_sb sb = new();
    bit          no_gaps;
    int          last_slot;

    segment_table_insert u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_action(i_action), .i_seg_id(i_seg_id), .i_virt_seg_id(i_virt_seg_id),
        .i_read_index(i_read_index), .o_valid(o_valid), .o_slot(o_slot),
        .o_was_castout(o_was_castout), .o_entry_valid(o_entry_valid),
        .o_esid_out(o_esid_out), .o_vsid_out(o_vsid_out),
        .o_cleared_count(o_cleared_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        seg_result_t r;
        if (i_rst_n && o_valid) begin
            r.slot = o_slot;
            r.castout = o_was_castout;
            r.valid = o_entry_valid;
            r.esid = o_esid_out;
            r.vsid = o_vsid_out;
            r.count = o_cleared_count;
            sb.check_result(r);
        end
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // start stays high after an accepted item until the next item or an idle gap
    task automatic send_item(logic [1:0] act, logic [ESID_W-1:0] sid,
                             logic [VSID_W-1:0] vid, logic [IDX_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_action <= act;
        i_seg_id <= sid;
        i_virt_seg_id <= vid;
        i_read_index <= idx;
        start <= 1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_item(act, sid, vid, idx);
        if (act == ACT_INSERT) last_slot = sb.pending[$].slot;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_thresh(logic [ESID_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.thresh = v;
    endtask

    function automatic logic [ESID_W-1:0] pick_esid();
        int k;
        logic [ESID_W-1:0] e;
        k = $urandom_range(0, 99);
        e = ESID_W'({$urandom(), $urandom()});
        if (k < 50) begin
            e[4:0] = 5'($urandom_range(0, 3));
        end else if (k < 65) begin
            e = {4'($urandom_range(1, 15)), 32'h0};
        end
        return e;
    endfunction

    task automatic random_items(int n);
        int k, idx;
        for (int i = 0; i < n; i++) begin
            if (i % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (k < 60) begin
                send_item(ACT_INSERT, pick_esid(), VSID_W'({$urandom(), $urandom()}), '0);
            end else if (k < 68) begin
                send_item(ACT_FLUSH, ESID_W'({$urandom(), $urandom()}),
                          VSID_W'({$urandom(), $urandom()}), IDX_W'($urandom()));
            end else if (k < 94) begin
                idx = $urandom_range(0, 255);
                for (int t = 0; t < 64 && !sb.written[idx]; t++) idx = $urandom_range(0, 255);
                if (!sb.written[idx]) idx = last_slot;
                send_item(ACT_READ, ESID_W'({$urandom(), $urandom()}),
                          VSID_W'({$urandom(), $urandom()}), IDX_W'(idx));
            end else begin
                send_item(ACT_UNUSED, ESID_W'({$urandom(), $urandom()}),
                          VSID_W'({$urandom(), $urandom()}), IDX_W'($urandom()));
            end
        end
    endtask

    initial begin
        sb.reset_state();
        no_gaps = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        write_thresh(THRESH_RESET);

        // kernel-only entries fill groups 0 and 31, then nothing qualifies for castout
        for (int i = 0; i < 16; i++) begin
            send_item(ACT_INSERT, {4'(1 + i % 15), 32'h0},
                      VSID_W'({$urandom(), $urandom()}), '0);
        end
        send_item(ACT_INSERT, {4'hF, 32'h0}, '0, '0);
        send_item(ACT_INSERT, 36'hFFFFFFFFF, {VSID_W{1'b1}}, '0);
        send_item(ACT_INSERT, 36'h0, '0, '0);
        send_item(ACT_READ, '0, '0, 8'd0);
        send_item(ACT_READ, '1, '1, 8'd255);
        send_item(ACT_FLUSH, '0, '0, '0);
        send_item(ACT_UNUSED, '1, '1, '1);
        send_item(ACT_READ, '0, '0, 8'd248);

        random_items(100);
        write_thresh('0);
        random_items(100);
        write_thresh(36'hFFFFFFFFF);
        random_items(100);
        write_thresh(ESID_W'({$urandom(), $urandom()}));
        random_items(50);
        write_thresh(THRESH_RESET);
        random_items(50);

        drain();
        repeat (50) @(negedge i_clk);
        $display("Checked %0d results: %0d castouts, %0d with no qualifying entry, %0d errors",
                 sb.n_checked, sb.n_castout, sb.n_noqual, sb.errors);
        $display("Thresholds covered: reset value, zero, all ones and a random value");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== segment_table_insert.f =====
rtl/sti_pkg.sv
rtl/sti_ram.sv
rtl/sti_ctrl.sv
rtl/sti_dp.sv
rtl/segment_table_insert.sv
tb/segment_table_insert_tb.sv
